// ----- rtl/core/scpr_pkg.sv -----
package scpr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic wr;
      logic set_ref;
      logic step;
      logic advance;
   } cell_ctl_type;

   localparam logic [4:0] FRAMES_IN_USE_RESET = 5'd16;

endpackage

// ----- rtl/core/second_chance_page_replacement.sv -----
// Second-chance (clock) page replacement. One request beat (start high while busy is low)
// carries a page number; exactly one response beat follows with rsp_valid high for one
// cycle, and the receiver cannot stall it. A hit or a fill into a free frame is answered
// from ST_LOOKUP. A miss with every frame in use goes on to ST_SWEEP, where the hand clears
// each set reference bit it meets (at most frames_filled) until one is clear: the hand
// is a token that the frame cells pass to their neighbor, one frame per cycle. busy stays
// high until the cycle rsp_valid rises, and a new request may start in that same cycle.
// csr_write_data sets how many frames are used (0 acts as 1, above FRAMES as FRAMES).
module second_chance_page_replacement #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page_number,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [3:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page,
   output logic [31:0] rsp_fault_total
);

   localparam int KEY_BITS = (PAGE_BITS < 16) ? PAGE_BITS : 16;
   localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W    = $clog2(FRAMES + 1);
   localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

   scpr_pkg::state_type state_ff, state_in;

   logic [4:0]          limit_ff;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   logic [31:0]         fault_ff, fault_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                rsp_ev_ff, rsp_ev_in;
   logic [KEY_BITS-1:0] rsp_evp_ff, rsp_evp_in;
   logic [31:0]         rsp_fault_ff, rsp_fault_in;

   scpr_pkg::cell_ctl_type ctl [FRAMES];
   logic [FRAMES-1:0]   match_vec, victim_vec, tok_out_vec, tok_in_vec, at_end, fill_sel;
   logic [KEY_BITS-1:0] cell_page [FRAMES];

   logic                any_hit, any_victim, full;
   logic [IDX_W-1:0]    hit_idx, victim_idx, fill_idx;
   logic [KEY_BITS-1:0] victim_page;
   logic [4:0]          limit_eff;

   // frame cells
   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      scpr_cell #(
         .KEY_BITS (KEY_BITS),
         .FIRST    (i == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[i]),
         .key      (key_ff),
         .tok_prev (tok_in_vec[i]),
         .tok_out  (tok_out_vec[i]),
         .match    (match_vec[i]),
         .victim   (victim_vec[i]),
         .page     (cell_page[i])
      );
      assign at_end[i]   = (filled_ff == CNT_W'(i + 1));
      assign fill_sel[i] = (filled_ff == CNT_W'(i));
      if (i == 0) begin : g_wrap
         assign tok_in_vec[i] = |(tok_out_vec & at_end);
      end else begin : g_link
         assign tok_in_vec[i] = tok_out_vec[i-1] && !at_end[i-1];
      end
   end

   always_comb begin
      hit_idx     = '0;
      victim_idx  = '0;
      fill_idx    = '0;
      victim_page = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (match_vec[i])  hit_idx    = hit_idx | IDX_W'(i);
         if (victim_vec[i]) begin
            victim_idx  = victim_idx | IDX_W'(i);
            victim_page = victim_page | cell_page[i];
         end
         if (fill_sel[i])   fill_idx   = fill_idx | IDX_W'(i);
      end
   end

   assign any_hit    = |match_vec;
   assign any_victim = |victim_vec;
   assign limit_eff  = (limit_ff == 5'd0) ? 5'd1 : limit_ff;
   assign full       = (filled_ff >= CNT_W'(FRAMES)) ||
                       (CMP_W'(filled_ff) >= CMP_W'(limit_eff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (start) state_in = scpr_pkg::ST_LOOKUP;
         end
         scpr_pkg::ST_LOOKUP: begin
            if (any_hit || !full) state_in = scpr_pkg::ST_IDLE;
            else                  state_in = scpr_pkg::ST_SWEEP;
         end
         scpr_pkg::ST_SWEEP: begin
            if (any_victim) state_in = scpr_pkg::ST_IDLE;
         end
         default: state_in = scpr_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      key_in       = key_ff;
      filled_in    = filled_ff;
      fault_in     = fault_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evp_in   = rsp_evp_ff;
      rsp_fault_in = rsp_fault_ff;
      for (int i = 0; i < FRAMES; i++) begin
         ctl[i] = '0;
      end
      case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (start) key_in = req_page_number[KEY_BITS-1:0];
         end
         scpr_pkg::ST_LOOKUP: begin
            if (any_hit) begin
               for (int i = 0; i < FRAMES; i++) begin
                  ctl[i].set_ref = match_vec[i];
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_idx_in   = hit_idx;
               rsp_ev_in    = 1'b0;
               rsp_evp_in   = '0;
               rsp_fault_in = fault_ff;
            end else if (!full) begin
               for (int i = 0; i < FRAMES; i++) begin
                  ctl[i].wr = fill_sel[i];
               end
               filled_in    = filled_ff + CNT_W'(1);
               fault_in     = fault_ff + 32'd1;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_idx_in   = fill_idx;
               rsp_ev_in    = 1'b0;
               rsp_evp_in   = '0;
               rsp_fault_in = fault_ff + 32'd1;
            end
         end
         scpr_pkg::ST_SWEEP: begin
            if (any_victim) begin
               for (int i = 0; i < FRAMES; i++) begin
                  ctl[i].wr      = victim_vec[i];
                  ctl[i].advance = 1'b1;
               end
               fault_in     = fault_ff + 32'd1;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_idx_in   = victim_idx;
               rsp_ev_in    = 1'b1;
               rsp_evp_in   = victim_page;
               rsp_fault_in = fault_ff + 32'd1;
            end else begin
               for (int i = 0; i < FRAMES; i++) begin
                  ctl[i].step = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpr_pkg::ST_IDLE;
         limit_ff     <= scpr_pkg::FRAMES_IN_USE_RESET;
         filled_ff    <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_fault_ff <= '0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_fault_ff <= rsp_fault_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_evp_ff <= rsp_evp_in;
   end

   assign busy              = (state_ff != scpr_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = 4'(rsp_idx_ff);
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = 16'(rsp_evp_ff);
   assign rsp_fault_total   = rsp_fault_ff;

   // the hand token is held by exactly one frame
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(tok_out_vec | victim_vec))
      else $error("clock hand token lost or duplicated");

   a_no_hit_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
      else $error("response reports both hit and eviction");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $stable(rsp_fault_total))
      else $error("fault count moved on a hit");

   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scpr_pkg::ST_SWEEP) |-> (filled_ff != '0) && busy)
      else $error("sweep entered with no frames filled");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request beat not taken up");

endmodule

// ----- rtl/core/scpr_cell.sv -----
module scpr_cell #(
   parameter int KEY_BITS = 16,
   parameter bit FIRST    = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scpr_pkg::cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]   key,
   input  logic                  tok_prev,
   output logic                  tok_out,
   output logic                  match,
   output logic                  victim,
   output logic [KEY_BITS-1:0]   page
);

   logic [KEY_BITS-1:0] page_ff;
   logic                valid_ff, valid_in;
   logic                ref_ff, ref_in;
   logic                tok_ff, tok_in;

   assign match   = valid_ff && (page_ff == key);
   assign victim  = tok_ff && !ref_ff;
   assign tok_out = tok_ff && (ref_ff || ctl.advance);
   assign page    = page_ff;

   always_comb begin
      valid_in = valid_ff;
      ref_in   = ref_ff;
      tok_in   = tok_ff;
      if (ctl.step || ctl.advance) begin
         tok_in = tok_prev || (tok_ff && !tok_out);
      end
      if (ctl.step && tok_ff && ref_ff) begin
         ref_in = 1'b0;
      end
      if (ctl.set_ref) begin
         ref_in = 1'b1;
      end
      if (ctl.wr) begin
         valid_in = 1'b1;
         ref_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ref_ff   <= 1'b0;
         tok_ff   <= FIRST;
      end else begin
         valid_ff <= valid_in;
         ref_ff   <= ref_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         page_ff <= key;
      end
   end

endmodule

// ----- sim/page_replacement_checker.sv -----
`timescale 1ns / 1ps

module page_replacement_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_page_number,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_hit,
   input  logic [3:0]  rsp_frame_index,
   input  logic        rsp_evicted_valid,
   input  logic [15:0] rsp_evicted_page,
   input  logic [31:0] rsp_fault_total,
   output int          mismatches,
   output int          pending,
   output int          hits,
   output int          evictions
);

   localparam int NUM_FRAMES = 16;

   typedef struct packed {
      logic        hit;
      logic [3:0]  frame_index;
      logic        evicted_valid;
      logic [15:0] evicted_page;
      logic [31:0] fault_total;
   } access_result_type;

   access_result_type expected_results[$];

   logic [15:0] frame_page [NUM_FRAMES];
   logic        frame_valid [NUM_FRAMES];
   logic        ref_bit [NUM_FRAMES];
   logic [3:0]  hand;
   logic [4:0]  filled;
   logic [31:0] faults;
   logic [4:0]  frame_limit_reg;
   int          mismatch_count;
   int          checked_count;
   int          hit_count;
   int          evict_count;

   task automatic predict_reference(input logic [15:0] page, output access_result_type r);
      int   i;
      int   lim;
      int   n;
      int   h;
      int   steps;
      logic found;
      r = '0;
      found = 1'b0;
      for (i = 0; i < filled; i++) begin
         if (!found && frame_valid[i] && frame_page[i] == page) begin
            found = 1'b1;
            r.frame_index = i[3:0];
         end
      end
      if (found) begin
         r.hit = 1'b1;
         ref_bit[r.frame_index] = 1'b1;
      end else begin
         faults = faults + 32'd1;
         lim = (frame_limit_reg == 5'd0) ? 1 :
               (frame_limit_reg > NUM_FRAMES) ? NUM_FRAMES : frame_limit_reg;
         if (filled < lim) begin
            r.frame_index = filled[3:0];
            frame_page[filled] = page;
            frame_valid[filled] = 1'b1;
            ref_bit[filled] = 1'b0;
            filled = filled + 5'd1;
         end else begin
            n = filled;
            h = hand;
            if (h >= n) h = 0;
            steps = 0;
            while (steps < n && ref_bit[h]) begin
               ref_bit[h] = 1'b0;
               h = (h + 1 == n) ? 0 : h + 1;
               steps++;
            end
            r.frame_index = h[3:0];
            r.evicted_valid = 1'b1;
            r.evicted_page = frame_page[h];
            frame_page[h] = page;
            frame_valid[h] = 1'b1;
            ref_bit[h] = 1'b0;
            hand = (h + 1 == n) ? 4'd0 : 4'(h + 1);
         end
      end
      r.fault_total = faults;
   endtask

   always @(posedge clock) begin
      access_result_type want;
      access_result_type got;
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_valid[i] = 1'b0;
            ref_bit[i] = 1'b0;
         end
         hand = '0;
         filled = '0;
         faults = '0;
         frame_limit_reg = scpr_pkg::FRAMES_IN_USE_RESET;
         expected_results.delete();
         mismatch_count = 0;
         checked_count = 0;
         hit_count = 0;
         evict_count = 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_hit, rsp_frame_index, rsp_evicted_valid, rsp_evicted_page,
                   rsp_fault_total};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing outstanding: hit=%0d frame=%0d",
                           $realtime, rsp_hit, rsp_frame_index);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result %0d expected hit=%0d frame=%0d evict=%0d/%h faults=%0d",
                              $realtime, checked_count,
                              want.hit, want.frame_index, want.evicted_valid,
                              want.evicted_page, want.fault_total);
                     $display("   got hit=%0d frame=%0d evict=%0d/%h faults=%0d",
                              got.hit, got.frame_index, got.evicted_valid,
                              got.evicted_page, got.fault_total);
                  end
               end
               if (want.hit) hit_count++;
               if (want.evicted_valid) evict_count++;
               checked_count++;
            end
         end
         if (csr_write_enable)
            frame_limit_reg = csr_write_data;
         if (start && !busy) begin
            predict_reference(req_page_number, want);
            expected_results.insert(expected_results.size(), want);
         end
      end
      mismatches <= mismatch_count;
      pending    <= expected_results.size();
      hits       <= hit_count;
      evictions  <= evict_count;
   end

endmodule

// ----- sim/tb_second_chance_page_replacement.sv -----
`timescale 1ns / 1ps

module tb_second_chance_page_replacement;

   localparam int IDLE_LIMIT  = 2000;
   localparam int RANDOM_REFS = 750;
   localparam int POOL_MAX    = 20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_page_number;
   logic        csr_write_enable;
   logic [4:0]  csr_write_data;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [3:0]  rsp_frame_index;
   logic        rsp_evicted_valid;
   logic [15:0] rsp_evicted_page;
   logic [31:0] rsp_fault_total;

   int mismatches;
   int pending;
   int hits;
   int evictions;
   int refs_sent;
   int settings_used;
   bit no_idle;

   second_chance_page_replacement i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   page_replacement_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .mismatches        (mismatches),
      .pending           (pending),
      .hits              (hits),
      .evictions         (evictions)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: cycles with no beat on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_ref(input logic [15:0] page);
      while (!no_idle && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (busy) @(posedge clock);
      refs_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic set_frame_limit(input logic [4:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [15:0] pool [POOL_MAX];
      logic [15:0] page;
      logic [4:0]  lim;
      int          pool_size;
      int          random_sent;
      int          phase;
      int          phase_len;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_page_number  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      no_idle = 1'b0;
      refs_sent = 0;
      settings_used = 0;
      random_sent = 0;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero frames acts as one; all bits set sweeps back to the start
      set_frame_limit(5'd0);
      send_ref(16'h0000);
      send_ref(16'hFFFF);
      send_ref(16'hFFFF);
      send_ref(16'h1234);
      // limit raised with one frame filled, then a full-ref sweep over three
      set_frame_limit(5'd3);
      send_ref(16'hAAAA);
      send_ref(16'h5555);
      send_ref(16'h1234);
      send_ref(16'hAAAA);
      send_ref(16'h5555);
      send_ref(16'h0F0F);
      // above the frame count acts as the full table
      set_frame_limit(5'd31);
      send_ref(16'h8000);
      send_ref(16'h0001);
      // limit lowered below the filled count
      set_frame_limit(5'd2);
      send_ref(16'h7FFF);
      send_ref(16'hFFFF);

      while (random_sent < RANDOM_REFS) begin
         if (phase == 0) lim = 5'd16;
         else begin
            case ($urandom_range(0, 5))
               0:       lim = 5'd0;
               1:       lim = 5'd1;
               2:       lim = 5'd16;
               3:       lim = 5'($urandom_range(17, 31));
               default: lim = 5'($urandom_range(2, 15));
            endcase
         end
         set_frame_limit(lim);
         pool_size = $urandom_range(1, POOL_MAX);
         for (int i = 0; i < pool_size; i++) pool[i] = 16'($urandom_range(0, 65535));
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            no_idle = (random_sent >= 300 && random_sent < 450);
            if ($urandom_range(0, 99) < 75) page = pool[$urandom_range(0, pool_size - 1)];
            else page = 16'($urandom_range(0, 65535));
            send_ref(page);
            random_sent++;
         end
         phase++;
      end

      drain();
      repeat (24) @(posedge clock);
      $display("Run covered %0d page references under %0d frame-limit settings.",
               refs_sent, settings_used);
      $display("Predicted %0d hits and %0d evictions; %0d mismatches, %0d results missing.",
               hits, evictions, mismatches, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/scpr_pkg.sv
rtl/core/scpr_cell.sv
rtl/core/second_chance_page_replacement.sv
sim/page_replacement_checker.sv
sim/tb_second_chance_page_replacement.sv
